FILE: sv/cbe_pkg.sv
// shared constants, types and helpers for the cubic bezier point evaluator
// no dependencies; used by every cbe_* module and the top level
`timescale 1ns / 1ps

package cbe_pkg;

   // fixed point
   localparam int FRAC_BITS  = 16;
   localparam int IO_W       = 24;
   localparam int REG_W      = 20;
   localparam int COEF_W     = 24;
   localparam int ACC_W      = 25;
   localparam int PROD_W     = ACC_W + FRAC_BITS + 1;
   localparam int T_CMP_W    = IO_W + 2;

   // configuration registers
   localparam int NUM_REGS   = 8;
   localparam int CSR_IDX_W  = $clog2(NUM_REGS);

   localparam int REG_CTRL0_X = 0;
   localparam int REG_CTRL0_Y = 1;
   localparam int REG_CTRL1_X = 2;
   localparam int REG_CTRL1_Y = 3;
   localparam int REG_CTRL2_X = 4;
   localparam int REG_CTRL2_Y = 5;
   localparam int REG_CTRL3_X = 6;
   localparam int REG_CTRL3_Y = 7;

   localparam int AXES   = 2;
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;

   // pipeline: input, three multiply/add pairs, output
   localparam int NUM_STAGES = 8;

   typedef logic signed [REG_W-1:0]  ctrl_type;
   typedef logic signed [COEF_W-1:0] coef_word_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [IO_W-1:0]   io_type;

   typedef struct packed {
      coef_word_type a;
      coef_word_type b;
      coef_word_type c;
      coef_word_type d;
   } coef_type;

   typedef struct packed {
      logic [FRAC_BITS-1:0] t_frac;
      logic                 t_low;
      logic                 t_high;
   } side_type;

   typedef struct packed {
      logic mul_load;
      logic add_load;
   } stage_ctl_type;

   localparam ctrl_type CTRL_ONE   = ctrl_type'(longint'(1) << FRAC_BITS);
   localparam ctrl_type CTRL_ZERO  = '0;

   localparam prod_type HALF = prod_type'(longint'(1) << (FRAC_BITS - 1));

   localparam io_type IO_MAX = {1'b0, {(IO_W-1){1'b1}}};
   localparam io_type IO_MIN = {1'b1, {(IO_W-1){1'b0}}};

   // value returned for t at or above one, saturated when one does not fit
   localparam io_type ONE_OUT = (FRAC_BITS >= IO_W - 1) ? IO_MAX
                                : io_type'(longint'(1) << FRAC_BITS);

   localparam logic signed [T_CMP_W-1:0] ONE_CMP =
      (T_CMP_W)'(longint'(1) << FRAC_BITS);

   function automatic coef_word_type ext_ctrl(input ctrl_type p);
      return {{(COEF_W-REG_W){p[REG_W-1]}}, p};
   endfunction

endpackage

FILE: sv/cubic_bezier_point_eval.sv
// top level of the cubic bezier point evaluator: pipeline control and stages
// depends on cbe_pkg, cbe_coef, cbe_horner, cbe_out
`timescale 1ns / 1ps

//  channel   ports                                   direction   beat
//  req       req_valid req_stall req_param_t          in          one t, signed Q7.16
//  rsp       rsp_valid rsp_stall rsp_point_x/_y       out         one point, signed Q7.16
//  csr       csr_wr_en csr_index csr_wr_data          in          one control coordinate
//
//  one beat per cycle sustained while rsp_stall is low; a result is held in each
//  register stage in order, from input to output, before rsp_valid shows it
//  eight register stages: input, three multiply/round-add pairs, output
//  each stage holds its beat while the stage after it is full and stalled, so
//  bubbles close up and input keeps flowing while an output beat waits
//  reset is synchronous, clears the valid bits and loads the default curve
//  (0,0) (0,0) (1,1) (1,1); user must write control points only while idle, unenforced

module cubic_bezier_point_eval (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [23:0]            req_param_t,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [23:0]            rsp_point_x,
   output logic signed [23:0]            rsp_point_y,

   input  logic                          csr_wr_en,
   input  logic [cbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cbe_pkg::REG_W-1:0]     csr_wr_data
);

   localparam int STG_IN  = 0;
   localparam int STG_OUT = cbe_pkg::NUM_STAGES - 1;
   localparam int STEPS   = 3;

   // stage valid bits and the ready chain running back from the output
   logic valid_ff [cbe_pkg::NUM_STAGES];
   logic valid_in [cbe_pkg::NUM_STAGES];
   logic up_valid [cbe_pkg::NUM_STAGES];
   logic load     [cbe_pkg::NUM_STAGES];
   logic rdy      [cbe_pkg::NUM_STAGES+1];

   always_comb begin
      rdy[cbe_pkg::NUM_STAGES] = !rsp_stall;
      for (int k = cbe_pkg::NUM_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      for (int k = 0; k < cbe_pkg::NUM_STAGES; k++) begin
         up_valid[k] = (k == STG_IN) ? req_valid : valid_ff[(k == STG_IN) ? 0 : k - 1];
         load[k]     = rdy[k] && up_valid[k];
         valid_in[k] = rdy[k] ? up_valid[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < cbe_pkg::NUM_STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !rdy[STG_IN];
   assign rsp_valid = valid_ff[STG_OUT];

   // coefficients from the control points
   cbe_pkg::coef_type coef [cbe_pkg::AXES];

   cbe_coef u_coef (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .coef        (coef)
   );

   // input stage: classify t against the ends of the unit interval
   cbe_pkg::side_type side_in0;
   cbe_pkg::side_type side0_ff;
   logic signed [cbe_pkg::T_CMP_W-1:0] t_cmp;

   always_comb begin
      t_cmp           = cbe_pkg::T_CMP_W'(req_param_t);
      side_in0.t_frac = req_param_t[cbe_pkg::FRAC_BITS-1:0];
      side_in0.t_low  = req_param_t[23] || (req_param_t == '0);
      side_in0.t_high = !req_param_t[23] && (t_cmp >= cbe_pkg::ONE_CMP);
   end

   always_ff @(posedge clock) begin
      if (load[STG_IN]) begin
         side0_ff <= side_in0;
      end
   end

   // horner chain: a -> *t + b -> *t + c -> *t + d
   cbe_pkg::acc_type       acc_chain  [STEPS+1][cbe_pkg::AXES];
   cbe_pkg::side_type      side_chain [STEPS+1];
   cbe_pkg::coef_word_type addend     [STEPS][cbe_pkg::AXES];
   cbe_pkg::stage_ctl_type step_ctl   [STEPS];

   always_comb begin
      for (int ax = 0; ax < cbe_pkg::AXES; ax++) begin
         acc_chain[0][ax] = cbe_pkg::acc_type'(coef[ax].a);
         addend[0][ax]    = coef[ax].b;
         addend[1][ax]    = coef[ax].c;
         addend[2][ax]    = coef[ax].d;
      end
      side_chain[0] = side0_ff;
      for (int s = 0; s < STEPS; s++) begin
         step_ctl[s].mul_load = load[2*s + 1];
         step_ctl[s].add_load = load[2*s + 2];
      end
   end

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      cbe_horner u_horner (
         .clock    (clock),
         .ctl      (step_ctl[s]),
         .acc_in   (acc_chain[s]),
         .side_in  (side_chain[s]),
         .addend   (addend[s]),
         .acc_out  (acc_chain[s+1]),
         .side_out (side_chain[s+1])
      );
   end

   // clamp cases, saturation, result register
   cbe_out u_out (
      .clock   (clock),
      .load    (load[STG_OUT]),
      .acc_in  (acc_chain[STEPS]),
      .side_in (side_chain[STEPS]),
      .point_x (rsp_point_x),
      .point_y (rsp_point_y)
   );

endmodule

FILE: sv/cbe_coef.sv
// control point registers and per-axis power-basis coefficients
// depends on cbe_pkg
`timescale 1ns / 1ps

module cbe_coef (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [cbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cbe_pkg::REG_W-1:0]     csr_wr_data,
   output cbe_pkg::coef_type             coef [cbe_pkg::AXES]
);

   cbe_pkg::ctrl_type ctrl_ff [cbe_pkg::NUM_REGS];
   cbe_pkg::coef_type coef_ff [cbe_pkg::AXES];
   cbe_pkg::coef_type coef_in [cbe_pkg::AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff[cbe_pkg::REG_CTRL0_X] <= cbe_pkg::CTRL_ZERO;
         ctrl_ff[cbe_pkg::REG_CTRL0_Y] <= cbe_pkg::CTRL_ZERO;
         ctrl_ff[cbe_pkg::REG_CTRL1_X] <= cbe_pkg::CTRL_ZERO;
         ctrl_ff[cbe_pkg::REG_CTRL1_Y] <= cbe_pkg::CTRL_ZERO;
         ctrl_ff[cbe_pkg::REG_CTRL2_X] <= cbe_pkg::CTRL_ONE;
         ctrl_ff[cbe_pkg::REG_CTRL2_Y] <= cbe_pkg::CTRL_ONE;
         ctrl_ff[cbe_pkg::REG_CTRL3_X] <= cbe_pkg::CTRL_ONE;
         ctrl_ff[cbe_pkg::REG_CTRL3_Y] <= cbe_pkg::CTRL_ONE;
      end else if (csr_wr_en) begin
         ctrl_ff[csr_index] <= csr_wr_data;
      end
   end

   // a = p3 - 3p2 + 3p1 - p0, b = 3p2 - 6p1 + 3p0, c = 3p1 - 3p0, d = p0
   always_comb begin
      cbe_pkg::coef_word_type p0, p1, p2, p3;
      cbe_pkg::coef_word_type p0x3, p1x3, p2x3;
      for (int ax = 0; ax < cbe_pkg::AXES; ax++) begin
         p0 = cbe_pkg::ext_ctrl(ctrl_ff[cbe_pkg::REG_CTRL0_X + ax]);
         p1 = cbe_pkg::ext_ctrl(ctrl_ff[cbe_pkg::REG_CTRL1_X + ax]);
         p2 = cbe_pkg::ext_ctrl(ctrl_ff[cbe_pkg::REG_CTRL2_X + ax]);
         p3 = cbe_pkg::ext_ctrl(ctrl_ff[cbe_pkg::REG_CTRL3_X + ax]);
         p0x3 = (p0 <<< 1) + p0;
         p1x3 = (p1 <<< 1) + p1;
         p2x3 = (p2 <<< 1) + p2;
         coef_in[ax].a = p3 - p2x3 + p1x3 - p0;
         coef_in[ax].b = p2x3 - (p1x3 <<< 1) + p0x3;
         coef_in[ax].c = p1x3 - p0x3;
         coef_in[ax].d = p0;
      end
   end

   // follows the registers in the next cycle; writes must land only while idle, which the block does not enforce
   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

   assign coef = coef_ff;

endmodule

FILE: sv/cbe_horner.sv
// one horner step for both axes: multiply stage then round-and-add stage
// depends on cbe_pkg
`timescale 1ns / 1ps

module cbe_horner (
   input  logic                   clock,
   input  cbe_pkg::stage_ctl_type ctl,
   input  cbe_pkg::acc_type       acc_in  [cbe_pkg::AXES],
   input  cbe_pkg::side_type      side_in,
   input  cbe_pkg::coef_word_type addend  [cbe_pkg::AXES],
   output cbe_pkg::acc_type       acc_out [cbe_pkg::AXES],
   output cbe_pkg::side_type      side_out
);

   cbe_pkg::prod_type prod_ff  [cbe_pkg::AXES];
   cbe_pkg::prod_type prod_in  [cbe_pkg::AXES];
   cbe_pkg::side_type side_mid_ff;
   cbe_pkg::acc_type  acc_ff   [cbe_pkg::AXES];
   cbe_pkg::acc_type  acc_in_n [cbe_pkg::AXES];
   cbe_pkg::side_type side_ff;
   cbe_pkg::prod_type rounded  [cbe_pkg::AXES];

   logic signed [cbe_pkg::FRAC_BITS:0] t_s;

   assign t_s = {1'b0, side_in.t_frac};

   always_comb begin
      for (int ax = 0; ax < cbe_pkg::AXES; ax++) begin
         prod_in[ax] = cbe_pkg::prod_type'(acc_in[ax]) * cbe_pkg::prod_type'(t_s);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_load) begin
         prod_ff     <= prod_in;
         side_mid_ff <= side_in;
      end
   end

   // round half up, floor shift, then add the next coefficient
   always_comb begin
      for (int ax = 0; ax < cbe_pkg::AXES; ax++) begin
         rounded[ax]  = (prod_ff[ax] + cbe_pkg::HALF) >>> cbe_pkg::FRAC_BITS;
         acc_in_n[ax] = cbe_pkg::acc_type'(rounded[ax][cbe_pkg::ACC_W-1:0])
                      + cbe_pkg::acc_type'(addend[ax]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.add_load) begin
         acc_ff  <= acc_in_n;
         side_ff <= side_mid_ff;
      end
   end

   assign acc_out  = acc_ff;
   assign side_out = side_ff;

endmodule

FILE: sv/cbe_out.sv
// output stage: clamp cases and saturation into the result register
// depends on cbe_pkg
`timescale 1ns / 1ps

module cbe_out (
   input  logic              clock,
   input  logic              load,
   input  cbe_pkg::acc_type  acc_in [cbe_pkg::AXES],
   input  cbe_pkg::side_type side_in,
   output cbe_pkg::io_type   point_x,
   output cbe_pkg::io_type   point_y
);

   cbe_pkg::io_type point_ff [cbe_pkg::AXES];
   cbe_pkg::io_type point_in [cbe_pkg::AXES];

   always_comb begin
      for (int ax = 0; ax < cbe_pkg::AXES; ax++) begin
         priority if (side_in.t_low) begin
            point_in[ax] = '0;
         end else if (side_in.t_high) begin
            point_in[ax] = cbe_pkg::ONE_OUT;
         end else if (acc_in[ax][cbe_pkg::ACC_W-1] == acc_in[ax][cbe_pkg::IO_W-1]) begin
            point_in[ax] = acc_in[ax][cbe_pkg::IO_W-1:0];
         end else if (acc_in[ax][cbe_pkg::ACC_W-1]) begin
            point_in[ax] = cbe_pkg::IO_MIN;
         end else begin
            point_in[ax] = cbe_pkg::IO_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         point_ff <= point_in;
      end
   end

   assign point_x = point_ff[cbe_pkg::AXIS_X];
   assign point_y = point_ff[cbe_pkg::AXIS_Y];

endmodule
